/* sv/ps2sa_pkg.sv */
package ps2sa_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int TABLE_LEN       = 58;

    localparam logic [7:0] SC_ACK       = 8'hFA;
    localparam logic [7:0] SC_F1        = 8'h3B;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BR = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BR = 8'hB6;
    localparam logic [7:0] SC_PREFIX    = 8'hE0;
    localparam logic [7:0] SC_CAPS_BR   = 8'hBA;
    localparam logic [7:0] SC_NUMLOCK   = 8'h45;
    localparam logic [7:0] SC_UP        = 8'h48;
    localparam logic [7:0] SC_DOWN      = 8'h50;
    localparam logic [7:0] SC_RIGHT     = 8'h4D;
    localparam logic [7:0] SC_LEFT      = 8'h4B;

    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_BRACKET   = 8'h5B;
    localparam logic [7:0] CH_UP        = 8'h41;
    localparam logic [7:0] CH_DOWN      = 8'h42;
    localparam logic [7:0] CH_RIGHT     = 8'h43;
    localparam logic [7:0] CH_LEFT      = 8'h44;
    localparam logic [7:0] KBD_LED_CMD  = 8'hED;

    typedef enum logic [1:0] {
        OP_ACK   = 2'd0,
        OP_CHAR  = 2'd1,
        OP_ARROW = 2'd2,
        OP_LED   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_KBD  = 2'd1,
        KIND_ACK  = 2'd2
    } t_kind;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    localparam logic [7:0] LOWER_MAP [TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20
    };

    localparam logic [7:0] UPPER_MAP [TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20
    };

endpackage

/* sv/ps2sa_front.sv */
module ps2sa_front
    import ps2sa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_scan_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic       r_shift;
    logic       r_caps;
    logic       r_ext;
    logic       n_shift;
    logic       n_caps;
    logic       n_ext;
    logic       w_accept;
    logic       w_hit;
    logic [7:0] w_char;
    logic [5:0] w_idx;

    assign w_accept = i_valid && !i_full;
    assign w_idx    = i_scan_byte[5:0];

    always_comb begin
        w_char = 8'h00;
        if (i_scan_byte < 8'(TABLE_LEN)) begin
            w_char = (r_shift || r_caps) ? UPPER_MAP[w_idx] : LOWER_MAP[w_idx];
        end
    end

    always_comb begin
        n_shift     = r_shift;
        n_caps      = r_caps;
        n_ext       = r_ext;
        w_hit       = 1'b0;
        o_cmd.op    = OP_CHAR;
        o_cmd.data  = 8'h00;
        if (i_scan_byte == SC_ACK) begin
            w_hit    = 1'b1;
            o_cmd.op = OP_ACK;
        end else if (i_scan_byte == SC_F1) begin
            n_ext = 1'b0;
        end else if (i_scan_byte == SC_LSHIFT || i_scan_byte == SC_RSHIFT) begin
            n_shift = 1'b1;
            n_ext   = 1'b0;
        end else if (i_scan_byte[7] || i_scan_byte == SC_NUMLOCK) begin
            if (i_scan_byte == SC_LSHIFT_BR || i_scan_byte == SC_RSHIFT_BR) begin
                n_shift = 1'b0;
            end
            if (i_scan_byte == SC_PREFIX) begin
                n_ext   = 1'b1;
                n_shift = 1'b0;
            end else begin
                n_ext = 1'b0;
            end
            if (i_scan_byte == SC_CAPS_BR) begin
                n_caps     = !r_caps;
                w_hit      = 1'b1;
                o_cmd.op   = OP_LED;
                o_cmd.data = {5'b00000, !r_caps, 2'b00};
            end
        end else if (r_ext) begin
            n_ext    = 1'b0;
            o_cmd.op = OP_ARROW;
            unique case (i_scan_byte)
                SC_UP: begin
                    w_hit      = 1'b1;
                    o_cmd.data = CH_UP;
                end
                SC_DOWN: begin
                    w_hit      = 1'b1;
                    o_cmd.data = CH_DOWN;
                end
                SC_RIGHT: begin
                    w_hit      = 1'b1;
                    o_cmd.data = CH_RIGHT;
                end
                SC_LEFT: begin
                    w_hit      = 1'b1;
                    o_cmd.data = CH_LEFT;
                end
                default: begin
                    w_hit = 1'b0;
                end
            endcase
        end else begin
            w_hit      = (w_char != 8'h00);
            o_cmd.data = w_char;
        end
    end

    assign o_push = w_accept && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_ext   <= 1'b0;
        end else if (w_accept) begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
            r_ext   <= n_ext;
        end
    end

endmodule

/* sv/ps2sa_queue.sv */
module ps2sa_queue
    import ps2sa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* sv/ps2sa_back.sv */
module ps2sa_back
    import ps2sa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_last
);

    logic [1:0] r_step;
    logic       r_valid;
    t_kind      r_kind;
    logic [7:0] r_data;
    logic       r_last;
    t_kind      w_kind;
    logic [7:0] w_data;
    logic       w_last;
    logic       w_load;

    always_comb begin
        unique case (i_head.op)
            OP_ACK: begin
                w_kind = KIND_ACK;
                w_data = 8'h00;
                w_last = 1'b1;
            end
            OP_CHAR: begin
                w_kind = KIND_CHAR;
                w_data = i_head.data;
                w_last = 1'b1;
            end
            OP_ARROW: begin
                w_kind = KIND_CHAR;
                w_data = (r_step == 2'd0) ? CH_ESC :
                         (r_step == 2'd1) ? CH_BRACKET : i_head.data;
                w_last = (r_step == 2'd2);
            end
            OP_LED: begin
                w_kind = KIND_KBD;
                w_data = (r_step == 2'd0) ? KBD_LED_CMD : i_head.data;
                w_last = (r_step == 2'd1);
            end
            default: begin
                w_kind = KIND_ACK;
                w_data = 8'h00;
                w_last = 1'b1;
            end
        endcase
    end

    assign w_load = !i_empty && (!r_valid || !i_stall);
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            if (!r_valid || !i_stall) begin
                r_valid <= !i_empty;
            end
            if (w_load) begin
                r_step <= w_last ? 2'd0 : r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= w_kind;
            r_data <= w_data;
            r_last <= w_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_data_byte = r_data;
    assign o_last      = r_last;

endmodule

/* sv/ps2_scancode_to_ascii_core.sv */
// channel   valid     stall     payload
// input     i_valid   o_stall   i_scan_byte
// output    o_valid   i_stall   o_kind, o_data_byte, o_last
//
// A scancode is taken every cycle while the command queue has room.
// Each scancode gives zero to three results, one per cycle from the output register
// while the output is not stalled; the output stage sets the sustained rate.
// Synchronous reset clears the key flags, the queue and the output valid.
// An output stall holds the output register; the queue fills and then stalls the input.
module ps2_scancode_to_ascii_core
    import ps2sa_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_scan_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_last
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_cmd;
    t_cmd w_head;

    assign o_stall = w_full;

    ps2sa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_scan_byte (i_scan_byte),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    ps2sa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    ps2sa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && !i_stall |=> o_valid)
        else $error("gap inside result burst");

    a_ack_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ACK |-> o_data_byte == 8'h00 && o_last)
        else $error("malformed acknowledge result");

endmodule

/* verif/ps2_scancode_to_ascii_core_test.sv */
`timescale 1ns / 1ps

module ps2_scancode_to_ascii_core_test
    import ps2sa_pkg::*;
();

    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         RX_HOLD_CYCLES = 300;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         MAX_REPORTS    = 10;
    localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;
    localparam logic [7:0] BREAK_BIT      = 8'h80;

    localparam logic [7:0] ARROW_CODES [4] = '{SC_UP, SC_DOWN, SC_RIGHT, SC_LEFT};

    localparam logic [7:0] PLAIN_KEYS [TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20
    };

    localparam logic [7:0] SHIFTED_KEYS [TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20
    };

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_key_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_scan_byte = 8'h00;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_data_byte;
    logic       o_last;

    logic       kb_shift  = 1'b0;
    logic       kb_caps   = 1'b0;
    logic       kb_prefix = 1'b0;
    logic [2:0] kb_leds   = 3'd0;

    t_key_result decoded_q [$];
    int          fail_count     = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          hold_requests  = 0;

    ps2_scancode_to_ascii_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_scan_byte (i_scan_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void queue_event(input t_kind kind, input logic [7:0] data,
                                        input logic last);
        t_key_result r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        decoded_q.push_back(r);
    endfunction

    function automatic void decode_scancode(input logic [7:0] code);
        logic [7:0] ch;
        if (code == SC_ACK) begin
            queue_event(KIND_ACK, 8'h00, 1'b1);
            return;
        end
        if (code == SC_F1) begin
            kb_prefix = 1'b0;
            return;
        end
        if (code[7]) begin
            if (code == SC_LSHIFT_BR || code == SC_RSHIFT_BR) begin
                kb_shift = 1'b0;
            end
        end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            kb_shift  = 1'b1;
            kb_prefix = 1'b0;
            return;
        end
        if (code[7] || code == SC_NUMLOCK) begin
            if (code == SC_PREFIX) begin
                kb_prefix = 1'b1;
                kb_shift  = 1'b0;
            end else begin
                kb_prefix = 1'b0;
            end
            if (code == SC_CAPS_BR) begin
                kb_caps    = ~kb_caps;
                kb_leds[2] = kb_caps;
                queue_event(KIND_KBD, KBD_LED_CMD, 1'b0);
                queue_event(KIND_KBD, {5'd0, kb_leds}, 1'b1);
            end
            return;
        end
        if (kb_prefix) begin
            kb_prefix = 1'b0;
            case (code)
                SC_UP:    ch = CH_UP;
                SC_DOWN:  ch = CH_DOWN;
                SC_RIGHT: ch = CH_RIGHT;
                SC_LEFT:  ch = CH_LEFT;
                default:  ch = 8'h00;
            endcase
            if (ch != 8'h00) begin
                queue_event(KIND_CHAR, CH_ESC, 1'b0);
                queue_event(KIND_CHAR, CH_BRACKET, 1'b0);
                queue_event(KIND_CHAR, ch, 1'b1);
            end
            return;
        end
        if (code < 8'(TABLE_LEN)) begin
            ch = (kb_shift || kb_caps) ? SHIFTED_KEYS[code[5:0]] : PLAIN_KEYS[code[5:0]];
            if (ch != 8'h00) begin
                queue_event(KIND_CHAR, ch, 1'b1);
            end
        end
    endfunction

    task automatic send_scan(input logic [7:0] code);
        if ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_valid     <= 1'b1;
        i_scan_byte <= code;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        decode_scancode(code);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    task automatic test_ack();
        send_scan(SC_ACK);
    endtask

    task automatic test_table_edges();
        logic [7:0] seq [6] = '{8'h00, 8'h01, 8'h39, SC_CAPS_MAKE, 8'h7F, 8'hFF};
        foreach (seq[i]) send_scan(seq[i]);
    endtask

    task automatic test_shift();
        logic [7:0] seq [7] = '{SC_LSHIFT, 8'h1E, SC_LSHIFT_BR, 8'h1E,
                                SC_RSHIFT, 8'h02, SC_RSHIFT_BR};
        foreach (seq[i]) send_scan(seq[i]);
    endtask

    task automatic test_caps();
        logic [7:0] seq [3] = '{SC_CAPS_BR, 8'h02, SC_CAPS_BR};
        foreach (seq[i]) send_scan(seq[i]);
    endtask

    task automatic test_prefix();
        logic [7:0] seq [7] = '{SC_PREFIX, SC_UP, SC_PREFIX, 8'h1E,
                                SC_PREFIX, SC_F1, 8'h1E};
        foreach (seq[i]) send_scan(seq[i]);
    endtask

    task automatic test_random_typing(input int n_items);
        int         sent;
        int         pick;
        logic [7:0] key;
        logic [7:0] shift_key;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            key  = 8'($urandom_range(TABLE_LEN - 1));
            if (pick < 30) begin
                send_scan(key);
                send_scan(key | BREAK_BIT);
                sent += 2;
            end else if (pick < 50) begin
                shift_key = (pick < 40) ? SC_LSHIFT : SC_RSHIFT;
                send_scan(shift_key);
                send_scan(key);
                send_scan(key | BREAK_BIT);
                send_scan(shift_key | BREAK_BIT);
                sent += 4;
            end else if (pick < 58) begin
                send_scan(SC_CAPS_MAKE);
                send_scan(SC_CAPS_BR);
                sent += 2;
            end else if (pick < 75) begin
                key = ARROW_CODES[2'($urandom_range(3))];
                send_scan(SC_PREFIX);
                send_scan(key);
                send_scan(SC_PREFIX);
                send_scan(key | BREAK_BIT);
                sent += 4;
            end else if (pick < 80) begin
                send_scan(SC_ACK);
                sent += 1;
            end else if (pick < 85) begin
                send_scan(SC_PREFIX);
                send_scan(8'($urandom_range(8'h7F)));
                sent += 2;
            end else begin
                send_scan(8'($urandom_range(8'hFF)));
                sent += 1;
            end
        end
    endtask

    task automatic test_receiver_hold();
        hold_requests++;
        repeat (8) begin
            send_scan(SC_PREFIX);
            send_scan(ARROW_CODES[2'($urandom_range(3))]);
        end
        wait_drained();
    endtask

    initial begin
        int hold_taken;
        int hold_left;
        hold_taken = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_taken) begin
                hold_taken = hold_requests;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_key_result exp_r;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (decoded_q.size() == 0) begin
                note_failure($sformatf("unexpected result: kind=%0d data=%02h last=%0d",
                                       o_kind, o_data_byte, o_last));
            end else begin
                exp_r = decoded_q.pop_front();
                if (o_kind !== exp_r.kind || o_data_byte !== exp_r.data
                        || o_last !== exp_r.last) begin
                    note_failure($sformatf(
                        "mismatch: expected kind=%0d data=%02h last=%0d, got kind=%0d data=%02h last=%0d",
                        exp_r.kind, exp_r.data, exp_r.last, o_kind, o_data_byte, o_last));
                end
            end
        end
    end

    initial begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0)
                    || (o_valid === 1'b1 && i_stall === 1'b0)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("ps2_scancode_to_ascii_core_test: FAIL");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(0, 0);
        test_ack();
        test_table_edges();
        test_shift();
        test_caps();
        test_prefix();
        wait_drained();

        test_random_typing(70);
        set_idling(72, 0);
        test_random_typing(70);
        set_idling(0, 72);
        test_random_typing(70);
        wait_drained();
        set_idling(31, 31);
        test_random_typing(70);

        set_idling(0, 0);
        test_receiver_hold();

        set_idling(31, 31);
        test_random_typing(40);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", decoded_q.size()));
        end
        if (fail_count == 0) begin
            $display("ps2_scancode_to_ascii_core_test: PASS");
        end else begin
            $display("ps2_scancode_to_ascii_core_test: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/ps2sa_pkg.sv
sv/ps2sa_front.sv
sv/ps2sa_queue.sv
sv/ps2sa_back.sv
sv/ps2_scancode_to_ascii_core.sv
verif/ps2_scancode_to_ascii_core_test.sv
